// ===== rtl/core/heightfield_bilinear_sampler_defines.svh =====
// Assertion macros shared by the heightfield sampler RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef HEIGHTFIELD_BILINEAR_SAMPLER_DEFINES_SVH
`define HEIGHTFIELD_BILINEAR_SAMPLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HBS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbs check failed");

// Next-cycle implication, checked outside reset.
`define HBS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbs check failed");

`endif

// ===== rtl/core/hbs_pkg.sv =====
// Shared constants, types and helpers of the heightfield bilinear sampler.
// No dependencies.
package hbs_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 256;
    localparam int FRAC_BITS   = 8;

    localparam int COLS_W      = $clog2(MAX_COLUMNS + 1);
    localparam int ROWS_W      = $clog2(MAX_ROWS + 1);
    localparam int XW          = $clog2(MAX_COLUMNS);
    localparam int YW          = $clog2(MAX_ROWS);
    localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int AREA_W      = COLS_W + ROWS_W;

    localparam int HEIGHT_W    = 32;
    localparam int SCALE_W     = 31;
    localparam int FRACT_W     = 24;
    localparam int INDEX_W     = 16;
    localparam int POS_W       = 21;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLUMNS = 3'd0,
        REG_ROWS    = 3'd1,
        REG_FORMAT  = 3'd2,
        REG_HMIN    = 3'd3,
        REG_HSCALE  = 3'd4
    } hbs_reg_t;

    localparam logic [1:0] FMT_RGB24 = 2'd0;
    localparam logic [1:0] FMT_RAW16 = 2'd1;
    localparam logic [1:0] FMT_RAW8  = 2'd2;

    typedef struct packed {
        logic [COLS_W-1:0]          cols;
        logic [ROWS_W-1:0]          rows;
        logic [1:0]                 fmt;
        logic signed [HEIGHT_W-1:0] hmin;
        logic [SCALE_W-1:0]         hscale;
    } hbs_cfg_t;

    typedef struct packed {
        logic                       en;
        logic [ADDR_W-1:0]          addr;
        logic signed [HEIGHT_W-1:0] data;
    } hbs_wr_t;

    function automatic logic [COLS_W-1:0] eff_cols(input logic [8:0] v);
        logic [COLS_W-1:0] r;
        if (v == 9'd0)
            r = COLS_W'(1);
        else if (32'(v) > 32'(MAX_COLUMNS))
            r = COLS_W'(MAX_COLUMNS);
        else
            r = COLS_W'(v);
        return r;
    endfunction

    function automatic logic [ROWS_W-1:0] eff_rows(input logic [8:0] v);
        logic [ROWS_W-1:0] r;
        if (v == 9'd0)
            r = ROWS_W'(1);
        else if (32'(v) > 32'(MAX_ROWS))
            r = ROWS_W'(MAX_ROWS);
        else
            r = ROWS_W'(v);
        return r;
    endfunction

endpackage

// ===== rtl/core/hbs_store.sv =====
// Height store: one synchronous RAM, one write and one registered read port.
// Depends on hbs_pkg.
module hbs_store import hbs_pkg::*;
(
    input  logic                       clk,
    input  hbs_wr_t                    wr,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic signed [HEIGHT_W-1:0] rd_data
);

    logic [HEIGHT_W-1:0] mem [STORE_DEPTH];
    logic [HEIGHT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = $signed(rd_data_reg);

endmodule

// ===== rtl/core/hbs_wpath.sv =====
// Write path: sample to Q0.24 fraction, scale, offset and saturate.
// Depends on hbs_pkg; drives the write port of hbs_store.
module hbs_wpath import hbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [INDEX_W-1:0] write_index,
    input  logic [FRACT_W-1:0] raw_sample,
    input  hbs_cfg_t           cfg,
    output logic               done,
    output hbs_wr_t            wr
);

    localparam int PROD_W = FRACT_W + SCALE_W;
    localparam int SUM_W  = HEIGHT_W + 2;

    logic                   v1_reg;
    logic                   v2_reg;
    logic [FRACT_W-1:0]     frac_reg;
    logic [INDEX_W-1:0]     idx_reg;
    logic                   in_grid_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic                   keep_reg;
    logic [PROD_W-1:0]      prod_reg;

    logic [FRACT_W-1:0]     frac_next;
    logic [AREA_W-1:0]      area;
    logic signed [SUM_W-1:0] sum;
    logic signed [HEIGHT_W-1:0] sat;

    always_comb
    begin
        unique case (cfg.fmt)
            FMT_RAW16: frac_next = {raw_sample[15:0], 8'd0} + FRACT_W'(raw_sample[15:8]);
            FMT_RAW8:  frac_next = FRACT_W'(raw_sample[7:0]) * FRACT_W'(65793);
            default:   frac_next = raw_sample;
        endcase
    end

    assign area = AREA_W'(cfg.cols) * AREA_W'(cfg.rows);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            frac_reg    <= frac_next;
            idx_reg     <= write_index;
            in_grid_reg <= (32'(write_index) < 32'(area));
        end
        if (v1_reg)
        begin
            prod_reg <= PROD_W'(frac_reg) * PROD_W'(cfg.hscale);
            addr_reg <= ADDR_W'(idx_reg);
            keep_reg <= in_grid_reg;
        end
    end

    assign sum = SUM_W'(cfg.hmin) + $signed(SUM_W'(prod_reg[PROD_W-1:FRACT_W]));

    always_comb
    begin
        if (sum > SUM_W'(32'sh7FFF_FFFF))
            sat = 32'sh7FFF_FFFF;
        else if (sum < -SUM_W'(33'sh0_8000_0000))
            sat = 32'sh8000_0000;
        else
            sat = sum[HEIGHT_W-1:0];
    end

    assign done    = v2_reg;
    assign wr.en   = v2_reg && keep_reg;
    assign wr.addr = addr_reg;
    assign wr.data = sat;

endmodule

// ===== rtl/core/heightfield_bilinear_sampler.sv =====
// Top level of the heightfield bilinear sampler: config, control, query datapath.
// Depends on hbs_pkg, hbs_store, hbs_wpath and the defines header.
//
// channel  | handshake            | payload
// in       | in_valid / in_ready  | req_type write_index raw_sample column_pos row_pos
// out      | out_valid / out_ready| height
// cfg      | cfg_valid / cfg_ready| cfg_index cfg_data
//
// A write goes through accept, scale and store; a query goes through address, index,
// the four cell reads through the single RAM read port, multiply/accumulate and finish.
// One item is in work at a time; a finished height waits in the output register
// while the next item is taken. A query stalls in its last cycle only while the
// output register is still full. The store has no reset; cells read as written.
`include "heightfield_bilinear_sampler_defines.svh"
module heightfield_bilinear_sampler import hbs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       req_type,
    input  logic [INDEX_W-1:0]         write_index,
    input  logic [FRACT_W-1:0]         raw_sample,
    input  logic signed [POS_W-1:0]    column_pos,
    input  logic signed [POS_W-1:0]    row_pos,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [HEIGHT_W-1:0] height,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    localparam int ONE_W  = FRAC_BITS + 1;
    localparam int W_W    = 2 * FRAC_BITS + 1;
    localparam int PROD_W = HEIGHT_W + W_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int CMP_W  = POS_W + COLS_W + ROWS_W + FRAC_BITS + 1;
    localparam int CX_W   = XW + FRAC_BITS;
    localparam int CY_W   = YW + FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WWAIT,
        S_QADDR,
        S_QIDX,
        S_QRUN,
        S_QFIN
    } state_t;

    state_t                   state_reg;
    logic [8:0]               cols_reg;
    logic [8:0]               rows_reg;
    logic [1:0]               fmt_reg;
    logic signed [HEIGHT_W-1:0] hmin_reg;
    logic [SCALE_W-1:0]       hscale_reg;

    logic signed [POS_W-1:0]  cp_reg;
    logic signed [POS_W-1:0]  rp_reg;
    logic [XW-1:0]            x1_reg;
    logic [YW-1:0]            y1_reg;
    logic [FRAC_BITS-1:0]     xf_reg;
    logic [FRAC_BITS-1:0]     yf_reg;
    logic [ADDR_W-1:0]        base_reg;
    logic [W_W-1:0]           w_reg [4];
    logic                     xlast_reg;
    logic                     ylast_reg;
    logic [2:0]               cnt_reg;
    logic                     rd_v_reg;
    logic [1:0]               rd_k_reg;
    logic                     mul_v_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic signed [HEIGHT_W-1:0] height_reg;

    hbs_cfg_t                 cfg;
    hbs_wr_t                  wr;
    logic                     wdone;
    logic                     in_acc;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [HEIGHT_W-1:0] rd_data;
    logic signed [CMP_W-1:0]  cmax;
    logic signed [CMP_W-1:0]  rmax;
    logic signed [CMP_W-1:0]  cpe;
    logic signed [CMP_W-1:0]  rpe;
    logic [CX_W-1:0]          cp_cl;
    logic [CY_W-1:0]          rp_cl;
    logic [ONE_W-1:0]         xi;
    logic [ONE_W-1:0]         yi;
    logic                     cell_keep;
    logic signed [HEIGHT_W-1:0] cell_val;
    logic signed [ACC_W-1:0]  acc_shift;

    assign cfg.cols   = eff_cols(cols_reg);
    assign cfg.rows   = eff_rows(rows_reg);
    assign cfg.fmt    = fmt_reg;
    assign cfg.hmin   = hmin_reg;
    assign cfg.hscale = hscale_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg   <= 9'd256;
            rows_reg   <= 9'd256;
            fmt_reg    <= FMT_RGB24;
            hmin_reg   <= '0;
            hscale_reg <= SCALE_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_COLUMNS: cols_reg   <= cfg_data[8:0];
                REG_ROWS:    rows_reg   <= cfg_data[8:0];
                REG_FORMAT:  fmt_reg    <= cfg_data[1:0];
                REG_HMIN:    hmin_reg   <= $signed(cfg_data);
                REG_HSCALE:  hscale_reg <= cfg_data[SCALE_W-1:0];
                default:     ;
            endcase
        end
    end

    hbs_wpath u_wpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_acc && !req_type),
        .write_index (write_index),
        .raw_sample  (raw_sample),
        .cfg         (cfg),
        .done        (wdone),
        .wr          (wr)
    );

    assign rd_en   = (state_reg == S_QRUN) && (cnt_reg < 3'd4);
    assign rd_addr = base_reg
                   + ((cnt_reg[0] ^ cnt_reg[1]) ? ADDR_W'(cfg.cols) : ADDR_W'(0))
                   + ADDR_W'(cnt_reg[1]);

    hbs_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // clamp both axes to 0 .. (size-1).0
    assign cmax = CMP_W'(32'(cfg.cols) - 1) <<< FRAC_BITS;
    assign rmax = CMP_W'(32'(cfg.rows) - 1) <<< FRAC_BITS;
    assign cpe  = CMP_W'(cp_reg);
    assign rpe  = CMP_W'(rp_reg);

    always_comb
    begin
        if (cpe < 0)
            cp_cl = '0;
        else if (cpe > cmax)
            cp_cl = cmax[CX_W-1:0];
        else
            cp_cl = cpe[CX_W-1:0];
        if (rpe < 0)
            rp_cl = '0;
        else if (rpe > rmax)
            rp_cl = rmax[CY_W-1:0];
        else
            rp_cl = rpe[CY_W-1:0];
    end

    assign xi = ONE_W'(1 << FRAC_BITS) - ONE_W'(xf_reg);
    assign yi = ONE_W'(1 << FRAC_BITS) - ONE_W'(yf_reg);

    always_comb
    begin
        unique case (rd_k_reg)
            2'd0:    cell_keep = 1'b1;
            2'd1:    cell_keep = !ylast_reg;
            2'd2:    cell_keep = !ylast_reg && !xlast_reg;
            default: cell_keep = !xlast_reg;
        endcase
    end

    assign cell_val  = cell_keep ? rd_data : '0;
    assign acc_shift = acc_reg >>> (2 * FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rd_v_reg      <= 1'b0;
            mul_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg  <= rd_en;
            mul_v_reg <= rd_v_reg;
            if (out_valid_reg && out_ready && (state_reg != S_QFIN))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        state_reg <= req_type ? S_QADDR : S_WWAIT;
                    end
                end
                S_WWAIT:
                begin
                    if (wdone)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_QADDR:
                begin
                    state_reg <= S_QIDX;
                end
                S_QIDX:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_QRUN;
                end
                S_QRUN:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd5)
                    begin
                        state_reg <= S_QFIN;
                    end
                end
                S_QFIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cp_reg <= column_pos;
            rp_reg <= row_pos;
        end
        if (state_reg == S_QADDR)
        begin
            x1_reg <= cp_cl[CX_W-1:FRAC_BITS];
            xf_reg <= cp_cl[FRAC_BITS-1:0];
            y1_reg <= rp_cl[CY_W-1:FRAC_BITS];
            yf_reg <= rp_cl[FRAC_BITS-1:0];
        end
        if (state_reg == S_QIDX)
        begin
            base_reg  <= ADDR_W'(x1_reg) + ADDR_W'(ADDR_W'(y1_reg) * ADDR_W'(cfg.cols));
            w_reg[0]  <= W_W'(xi) * W_W'(yi);
            w_reg[1]  <= W_W'(xi) * W_W'(yf_reg);
            w_reg[2]  <= W_W'(xf_reg) * W_W'(yf_reg);
            w_reg[3]  <= W_W'(xf_reg) * W_W'(yi);
            xlast_reg <= (COLS_W'(x1_reg) + COLS_W'(1)) >= cfg.cols;
            ylast_reg <= (ROWS_W'(y1_reg) + ROWS_W'(1)) >= cfg.rows;
            acc_reg   <= '0;
        end
        if (rd_en)
        begin
            rd_k_reg <= cnt_reg[1:0];
        end
        if (rd_v_reg)
        begin
            prod_reg <= PROD_W'(cell_val) * $signed({1'b0, w_reg[rd_k_reg]});
        end
        if (mul_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if ((state_reg == S_QFIN) && (!out_valid_reg || out_ready))
        begin
            height_reg <= acc_shift[HEIGHT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign height    = height_reg;

    `HBS_ASSERT_NOW(a_idle_pipe_empty, in_ready, !rd_v_reg && !mul_v_reg)
    `HBS_ASSERT_NOW(a_store_only_in_write, wr.en, state_reg == S_WWAIT)
    `HBS_ASSERT_NOW(a_fin_acc_done, state_reg == S_QFIN, !rd_v_reg && !mul_v_reg && !rd_en)
    `HBS_ASSERT_NEXT(a_fin_loads_out, (state_reg == S_QFIN) && !out_valid_reg, out_valid_reg)

endmodule
